// ----- rtl/lrr_pkg.sv -----
// ----------------------------------------------------------------------------
// lrr_pkg: shared definitions for the ranged LCG random source
// Widths, reset values, register indexes and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lrr_pkg;

  // Field and register widths.
  localparam int MULT_W  = 16;
  localparam int SEED_W  = 18;
  localparam int VAL_W   = 32;
  localparam int SPAN_W  = VAL_W + 1;
  localparam int PROD_W  = MULT_W + SEED_W + 1;
  localparam int DVD_W   = PROD_W;
  localparam int DSR_W   = VAL_W;
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Step counts of the divider for the two reductions.
  localparam logic [CNT_W-1:0] STEPS_MOD  = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] STEPS_SPAN = CNT_W'(SEED_W);

  // Reset values of the registers and of the seed.
  localparam logic [MULT_W-1:0] MULT_RST = MULT_W'(8121);
  localparam logic [SEED_W-1:0] INC_RST  = SEED_W'(28411);
  localparam logic [SEED_W-1:0] MOD_RST  = SEED_W'(134456);
  localparam logic [SEED_W-1:0] SEED_RST = SEED_W'(1234);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MULT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INC  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MOD  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = CFG_IDX_W'(3);

  // Source of the result word.
  typedef enum logic [1:0] {
    RES_RAW,
    RES_ZERO,
    RES_SEED,
    RES_REM
  } res_op_e;

  // Operand set for the shared divider.
  typedef enum logic {
    DIV_MOD,
    DIV_SPAN
  } div_sel_e;

  // Commands from the controller.
  typedef struct packed {
    logic     load_in;
    logic     mul;
    logic     div_start;
    div_sel_e div_sel;
    logic     seed_mask;
    logic     seed_div;
    logic     res_load;
    res_op_e  res_op;
    logic     out_load;
  } lrr_cmd_t;

  // Status toward the controller.
  typedef struct packed {
    logic kind;
    logic mod_zero;
    logic mag_zero;
    logic mag_gt_seed;
    logic div_done;
  } lrr_sts_t;

endpackage

// ----- rtl/lcg_random_with_range.sv -----
// ----------------------------------------------------------------------------
// lcg_random_with_range: LCG random source with optional range reduction
// Each draw sets seed = (mult*seed + add) mod modulus (low seed bits for a zero
// modulus) and returns either the new seed or low + (seed mod |high - low|).
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                  Word taken
//   s_axis    in         tuser: kind; tdata: range_low, high      tvalid&tready
//   m_axis    out        tuser: zero_span; tdata: value           tvalid&tready
//   cfg       in         cfg_index_i, cfg_data_i                  valid&ready
//
// A draw runs from acceptance through the multiply, a seed reduction in the
// bit-serial remainder unit and, when a range reduction needs it, a second
// pass through that unit; a zero modulus skips the first pass. A stalled
// m_axis adds its wait on top.
// Reset loads the register defaults and seed 1234; no clearing pass follows.
// The next draw is accepted while a finished word waits on m_axis.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module lcg_random_with_range import lrr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Draw requests.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*VAL_W-1:0]    s_axis_tdata,  // [31:0] range_low, [63:32] range_high
  input  logic                  s_axis_tuser,  // [0] kind
  // Draw results.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [VAL_W-1:0]      m_axis_tdata,  // [31:0] value
  output logic                  m_axis_tuser   // [0] zero_span
);

  lrr_cmd_t cmd;
  lrr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lrr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lrr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_kind_i   (s_axis_tuser),
    .in_low_i    (s_axis_tdata[VAL_W-1:0]),
    .in_high_i   (s_axis_tdata[2*VAL_W-1:VAL_W]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_value_o (m_axis_tdata),
    .out_flag_o  (m_axis_tuser)
  );

endmodule

// ----- rtl/lrr_divider.sv -----
// ----------------------------------------------------------------------------
// lrr_divider: bit-serial restoring remainder unit
// Produces dividend mod divisor, one dividend bit per cycle, taking the
// requested number of bits from the top of the dividend.
// ----------------------------------------------------------------------------
module lrr_divider import lrr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  input  logic [CNT_W-1:0] steps_i,
  output logic             done_o,
  output logic [DSR_W-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;

  // One restoring step: shift in the next bit and subtract when it fits.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d = diff[DSR_W] ? trial[DSR_W-1:0] : diff[DSR_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

`ifndef SYNTHESIS
  // A new operation must not start over one that is still running.
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  // The done pulse follows the last step and leaves the unit idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  // A running operation always has steps left.
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0)) else $error("divider busy with zero count");
`endif

endmodule

// ----- rtl/lrr_datapath.sv -----
// ----------------------------------------------------------------------------
// lrr_datapath: registers, seed update and range reduction
// Holds the configuration and the seed, forms mult*seed + add, drives the
// shared divider and builds the result and output words.
// ----------------------------------------------------------------------------
module lrr_datapath import lrr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_kind_i,
  input  logic [VAL_W-1:0]      in_low_i,
  input  logic [VAL_W-1:0]      in_high_i,
  input  lrr_cmd_t              cmd_i,
  output lrr_sts_t              sts_o,
  output logic [VAL_W-1:0]      out_value_o,
  output logic                  out_flag_o
);

  logic [MULT_W-1:0] mult_q;
  logic [SEED_W-1:0] inc_q;
  logic [SEED_W-1:0] mod_q;
  logic [SEED_W-1:0] seed_q, seed_d;
  logic              kind_q;
  logic [VAL_W-1:0]  low_q;
  logic [SPAN_W-1:0] span_q;
  logic [DSR_W-1:0]  mag_q;
  logic [PROD_W-1:0] next_q;
  logic [VAL_W-1:0]  res_val_q, res_val_d;
  logic              res_flag_q, res_flag_d;
  logic [VAL_W-1:0]  out_val_q;
  logic              out_flag_q;
  logic [SPAN_W-1:0] span_neg;
  logic [DVD_W-1:0]  div_dividend;
  logic [DSR_W-1:0]  div_divisor;
  logic [CNT_W-1:0]  div_steps;
  logic              div_done;
  logic [DSR_W-1:0]  div_rem;

  // Configuration registers; a write to an unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MULT_RST;
      inc_q  <= INC_RST;
      mod_q  <= MOD_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MULT) mult_q <= cfg_data_i[MULT_W-1:0];
      if (cfg_index_i == CFG_INC)  inc_q  <= cfg_data_i[SEED_W-1:0];
      if (cfg_index_i == CFG_MOD)  mod_q  <= cfg_data_i[SEED_W-1:0];
    end
  end

  // Seed: loaded by a register write, otherwise updated by a draw.
  always_comb begin
    seed_d = seed_q;
    priority if (cfg_we_i && (cfg_index_i == CFG_SEED)) begin
      seed_d = cfg_data_i[SEED_W-1:0];
    end else if (cmd_i.seed_mask) begin
      seed_d = next_q[SEED_W-1:0];
    end else if (cmd_i.seed_div) begin
      seed_d = div_rem[SEED_W-1:0];
    end else begin
      seed_d = seed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RST;
    end else begin
      seed_q <= seed_d;
    end
  end

  // Input capture; the span is taken exactly in one extra bit.
  assign span_neg = SPAN_W'(0) - span_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q <= in_kind_i;
      low_q  <= in_low_i;
      span_q <= {in_high_i[VAL_W-1], in_high_i} - {in_low_i[VAL_W-1], in_low_i};
    end
    if (cmd_i.mul) begin
      next_q <= PROD_W'(mult_q) * PROD_W'(seed_q) + PROD_W'(inc_q);
      mag_q  <= span_q[SPAN_W-1] ? span_neg[DSR_W-1:0] : span_q[DSR_W-1:0];
    end
  end

  // Operands of the shared divider.
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_MOD: begin
        div_dividend = next_q;
        div_divisor  = DSR_W'(mod_q);
        div_steps    = STEPS_MOD;
      end
      DIV_SPAN: begin
        div_dividend = {seed_q, (DVD_W - SEED_W)'(0)};
        div_divisor  = mag_q;
        div_steps    = STEPS_SPAN;
      end
      default: begin
        div_dividend = next_q;
        div_divisor  = DSR_W'(mod_q);
        div_steps    = STEPS_MOD;
      end
    endcase
  end

  lrr_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Result word selection.
  always_comb begin
    unique case (cmd_i.res_op)
      RES_RAW: begin
        res_val_d  = VAL_W'(seed_q);
        res_flag_d = 1'b0;
      end
      RES_ZERO: begin
        res_val_d  = low_q;
        res_flag_d = 1'b1;
      end
      RES_SEED: begin
        res_val_d  = low_q + VAL_W'(seed_q);
        res_flag_d = 1'b0;
      end
      RES_REM: begin
        res_val_d  = low_q + div_rem;
        res_flag_d = 1'b0;
      end
      default: begin
        res_val_d  = VAL_W'(seed_q);
        res_flag_d = 1'b0;
      end
    endcase
  end

  // Result and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_val_q  <= res_val_d;
      res_flag_q <= res_flag_d;
    end
    if (cmd_i.out_load) begin
      out_val_q  <= res_val_q;
      out_flag_q <= res_flag_q;
    end
  end

  // Status toward the controller.
  assign sts_o.kind        = kind_q;
  assign sts_o.mod_zero    = (mod_q == '0);
  assign sts_o.mag_zero    = (mag_q == '0);
  assign sts_o.mag_gt_seed = (mag_q > DSR_W'(seed_q));
  assign sts_o.div_done    = div_done;

  assign out_value_o = out_val_q;
  assign out_flag_o  = out_flag_q;

endmodule

// ----- rtl/lrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrr_ctrl: draw sequencer
// Steps one draw through multiply, seed reduction and range reduction, and
// owns the handshake of both stream sides.
// ----------------------------------------------------------------------------
module lrr_ctrl import lrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  input  lrr_sts_t sts_i,
  output lrr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_SPAN = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_MOD;
    cmd_o.res_op  = RES_RAW;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_RED;
      end
      S_RED: begin
        if (sts_i.mod_zero) begin
          cmd_o.seed_mask = 1'b1;
          state_d = S_SPAN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.seed_div = 1'b1;
          state_d = S_SPAN;
        end
      end
      S_SPAN: begin
        priority if (!sts_i.kind) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_op   = RES_RAW;
          state_d = S_DONE;
        end else if (sts_i.mag_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_op   = RES_ZERO;
          state_d = S_DONE;
        end else if (sts_i.mag_gt_seed) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_op   = RES_SEED;
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SPAN;
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd_o.div_sel = DIV_SPAN;
        if (sts_i.div_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_op   = RES_REM;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output word stays valid until taken or replaced.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // An accepted draw always goes on to the multiply step.
  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_MUL)) else $error("accept lost");
  // A new output word never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_ready_i)) else $error("output overwritten");
`endif

endmodule

// ----- sim/lcg_random_with_range_test.sv -----
// ----------------------------------------------------------------------------
// lcg_random_with_range_test: self-checking bench for the ranged LCG source
// Draw requests go in on s_axis and each result word is checked against a
// behavioral LCG kept in step with every accepted draw and register write.
// Directed cases cover reset defaults, range edges and register extremes;
// the random part runs several register settings with random bounds and
// random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg_random_with_range_test;
  import lrr_pkg::*;

  // Draw kinds on tuser.
  localparam logic KIND_RAW    = 1'b0;
  localparam logic KIND_RANGED = 1'b1;

  // Register indexes past the end of the map; writes there are dropped.
  localparam int CFG_UNUSED_FIRST = 4;
  localparam int CFG_UNUSED_LAST  = 2**CFG_IDX_W - 1;

  localparam int PHASE_COUNT = 6;
  localparam int PHASE_LEN   = 140;
  localparam int LATENCY     = 80;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             zero_span;
  } draw_res_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*VAL_W-1:0]    s_axis_tdata  = '0;  // [31:0] range_low, [63:32] range_high
  logic                  s_axis_tuser  = 1'b0;  // [0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [VAL_W-1:0]      m_axis_tdata;  // [31:0] value
  logic                  m_axis_tuser;  // [0] zero_span

  // Behavioral copy of the generator registers and seed.
  logic [MULT_W-1:0] lcg_mult;
  logic [SEED_W-1:0] lcg_inc;
  logic [SEED_W-1:0] lcg_mod;
  logic [SEED_W-1:0] lcg_seed;

  draw_res_t expected_draws[$];
  int        err_count   = 0;
  int        cycle_count = 0;
  int        n_draws     = 0;
  int        n_ranged    = 0;
  int        n_empty     = 0;
  int        n_settings  = 1;
  bit        steady_flow = 1'b0;

  lcg_random_with_range u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.",
               CYCLE_LIMIT, expected_draws.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Advance the seed and work out the word that one draw returns.
  function automatic draw_res_t predict_draw(input logic kind,
                                             input logic [VAL_W-1:0] lo,
                                             input logic [VAL_W-1:0] hi);
    longint unsigned product;
    longint          span;
    longint unsigned mag;
    draw_res_t       res;
    product = longint'(lcg_mult) * longint'(lcg_seed) + longint'(lcg_inc);
    lcg_seed = (lcg_mod != '0) ? SEED_W'(product % lcg_mod) : SEED_W'(product);
    res.zero_span = 1'b0;
    if (kind == KIND_RAW) begin
      res.value = VAL_W'(lcg_seed);
    end else begin
      n_ranged++;
      // The span is taken exactly, so a negative one uses its magnitude.
      span = longint'(signed'(hi)) - longint'(signed'(lo));
      mag = (span < 0) ? -span : span;
      if (mag == 0) begin
        res.value = lo;
        res.zero_span = 1'b1;
        n_empty++;
      end else begin
        res.value = lo + VAL_W'(longint'(lcg_seed) % mag);
      end
    end
    return res;
  endfunction

  // Result checker and random backpressure on the output stream.
  int stall_left = 0;
  always @(posedge clk_i) begin : result_check
    draw_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_draws.size() == 0) begin
          $error("Result word with no draw pending: value %0d, zero_span %0b",
                 signed'(m_axis_tdata), m_axis_tuser);
          err_count++;
        end else begin
          want = expected_draws.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("value: expected %0d, got %0d", signed'(want.value),
                   signed'(m_axis_tdata));
            err_count++;
          end
          if (m_axis_tuser !== want.zero_span) begin
            $error("zero_span: expected %0b, got %0b", want.zero_span, m_axis_tuser);
            err_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Write one register; valid stays high unless this is the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MULT: lcg_mult = data[MULT_W-1:0];
      CFG_INC:  lcg_inc  = data[SEED_W-1:0];
      CFG_MOD:  lcg_mod  = data[SEED_W-1:0];
      CFG_SEED: lcg_seed = data[SEED_W-1:0];
      default: ;
    endcase
    if (last) cfg_valid_i <= 1'b0;
  endtask

  // Load a full register setting, with junk above each field's width and a
  // trailing write to an index outside the map.
  task automatic apply_settings(input logic [MULT_W-1:0] mult,
                                input logic [SEED_W-1:0] inc,
                                input logic [SEED_W-1:0] modulus,
                                input logic [SEED_W-1:0] seed_val);
    write_reg(CFG_MULT, {16'($urandom), mult}, 1'b0);
    write_reg(CFG_INC,  {14'($urandom), inc}, 1'b0);
    write_reg(CFG_MOD,  {14'($urandom), modulus}, 1'b0);
    write_reg(CFG_SEED, {14'($urandom), seed_val}, 1'b0);
    write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
              $urandom, 1'b1);
    n_settings++;
  endtask

  // Send one draw request, after a random gap unless the flow is steady.
  task automatic send_draw(input logic kind, input logic [VAL_W-1:0] lo,
                           input logic [VAL_W-1:0] hi);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      s_axis_tuser  <= 1'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {hi, lo};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_draws.push_back(predict_draw(kind, lo, hi));
    n_draws++;
  endtask

  // Stop sending and wait until every pending word has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_draws.size() != 0);
  endtask

  // Draws straight out of reset check the default registers and seed.
  task automatic test_reset_defaults();
    send_draw(KIND_RAW, '0, '0);
    send_draw(KIND_RAW, '1, '1);
    send_draw(KIND_RANGED, 32'd0, 32'd1000);
    wait_drained();
  endtask

  // Bounds at the edges of the 32-bit range, negative and empty spans.
  task automatic test_range_edges();
    send_draw(KIND_RANGED, 32'd0, 32'd10);
    send_draw(KIND_RANGED, 32'd10, 32'd0);
    send_draw(KIND_RANGED, 32'd5, 32'd5);
    send_draw(KIND_RANGED, INT_MIN, INT_MAX);
    send_draw(KIND_RANGED, INT_MAX, INT_MIN);
    send_draw(KIND_RANGED, INT_MIN, INT_MIN);
    send_draw(KIND_RANGED, INT_MAX, INT_MAX);
    send_draw(KIND_RANGED, '1, 32'd0);
    send_draw(KIND_RANGED, -32'sd100, -32'sd50);
    send_draw(KIND_RANGED, 32'd1, 32'd300000);
    send_draw(KIND_RAW, INT_MAX, INT_MIN);
    wait_drained();
  endtask

  // Register extremes: unit, zero and full-width moduli, a seed loaded above
  // the modulus, a seed-only reload and a write outside the register map.
  task automatic test_register_edges();
    apply_settings('0, '0, SEED_W'(1), '0);
    send_draw(KIND_RAW, '0, '0);
    send_draw(KIND_RANGED, 32'd0, 32'd7);
    wait_drained();
    apply_settings('1, '1, '1, '1);
    send_draw(KIND_RAW, '0, '0);
    send_draw(KIND_RAW, '0, '0);
    wait_drained();
    apply_settings('1, '1, '0, '1);
    send_draw(KIND_RAW, '0, '0);
    send_draw(KIND_RANGED, INT_MAX, INT_MIN);
    wait_drained();
    apply_settings(MULT_RST, INC_RST, SEED_W'(1000), SEED_W'(200000));
    send_draw(KIND_RAW, '0, '0);
    wait_drained();
    write_reg(CFG_SEED, '1, 1'b1);
    send_draw(KIND_RAW, '0, '0);
    wait_drained();
    write_reg(CFG_IDX_W'(CFG_UNUSED_LAST), '1, 1'b1);
    send_draw(KIND_RAW, '0, '0);
    wait_drained();
  endtask

  // Random bounds: spans near the seed range most often, plus wide, empty,
  // extreme and small ones.
  task automatic pick_bounds(output logic [VAL_W-1:0] lo, output logic [VAL_W-1:0] hi);
    logic [VAL_W-1:0] edges [5];
    edges = '{INT_MIN, INT_MAX, '0, '1, 32'd1};
    lo = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: hi = lo + VAL_W'($urandom_range(0, 600000) - 300000);
      4, 5:       hi = $urandom;
      6:          hi = lo;
      7: begin
        lo = edges[$urandom_range(0, 4)];
        hi = edges[$urandom_range(0, 4)];
      end
      default: begin
        lo = VAL_W'($urandom_range(0, 2000) - 1000);
        hi = VAL_W'($urandom_range(0, 2000) - 1000);
      end
    endcase
  endtask

  // Random draws under a different register setting in each phase.
  task automatic test_random_draws();
    logic [VAL_W-1:0]  lo;
    logic [VAL_W-1:0]  hi;
    logic [SEED_W-1:0] small_mod;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      small_mod = SEED_W'($urandom_range(1, 64));
      case (phase)
        0: apply_settings('1, '1, '1, SEED_W'($urandom));
        1: apply_settings(MULT_W'($urandom), SEED_W'($urandom), '0, SEED_W'($urandom));
        2: apply_settings(MULT_W'($urandom), SEED_W'($urandom), small_mod,
                          SEED_W'($urandom_range(64, 2**SEED_W - 1)));
        3: apply_settings('0, SEED_W'($urandom), SEED_W'($urandom_range(1, 2**SEED_W - 1)),
                          SEED_W'($urandom));
        default: apply_settings(MULT_W'($urandom), SEED_W'($urandom),
                                SEED_W'($urandom_range(1, 2**SEED_W - 1)),
                                SEED_W'($urandom));
      endcase
      steady_flow = (phase == PHASE_COUNT - 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Let the block run dry once in the middle of a phase.
        if (phase == 2 && n == PHASE_LEN / 2) wait_drained();
        pick_bounds(lo, hi);
        send_draw(1'($urandom), lo, hi);
      end
      wait_drained();
    end
  endtask

  initial begin
    lcg_mult = MULT_RST;
    lcg_inc  = INC_RST;
    lcg_mod  = MOD_RST;
    lcg_seed = SEED_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_range_edges();
    test_register_edges();
    test_random_draws();

    // Catch any stray words after the last expected one.
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Checked %0d draws, %0d ranged and %0d of those with an empty span,",
             n_draws, n_ranged, n_empty);
    $display("across %0d register settings incl. zero, unit and full-width moduli.",
             n_settings);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lrr_pkg.sv
rtl/lrr_divider.sv
rtl/lrr_datapath.sv
rtl/lrr_ctrl.sv
rtl/lcg_random_with_range.sv
sim/lcg_random_with_range_test.sv
